@@ rtl/dfas_pkg.sv @@
// package: widths, opcodes, result type and digit helpers for the decimal float unit
`timescale 1ns / 1ps
`default_nettype none
package dfas_pkg;

  localparam int MANT_W      = 16;  // mantissa word width
  localparam int EXP_W       = 16;  // exponent word width
  localparam int MAG_W       = MANT_W + 1;  // magnitude of a mantissa, holds the negated minimum
  localparam int SUM_W       = 27;  // aligned operand and sum width (up to 2 * 32768 * 1000)
  localparam int TGT_W       = EXP_W + 2;   // exponent plus digit count, with headroom
  localparam int SHD_W       = TGT_W + 1;   // exponent difference
  localparam int SH_W        = 4;   // clamped alignment shift, -5 .. 3
  localparam int K_W         = 3;   // stripped zero count
  localparam int PROD_W      = 2 * MAG_W;
  localparam int DIGIT_LIMIT = 4;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_SUB     = 2'd1;
  localparam logic [1:0] CMD_MUL     = 2'd2;
  localparam int         CMD_MUL_BIT = 1;  // bit 1 set selects multiply

  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((1 << (MANT_W - 1)) - 1);

  typedef struct packed {
    logic signed [MANT_W-1:0] mant;
    logic signed [EXP_W-1:0]  expo;
    logic                     wrap;
  } byp_t;

  // decimal digit count of a magnitude below 10^5
  function automatic logic [K_W-1:0] ndigits(input logic [MAG_W-1:0] m);
    logic [K_W-1:0] n;
    if (m >= MAG_W'(10000)) n = 3'd5;
    else if (m >= MAG_W'(1000)) n = 3'd4;
    else if (m >= MAG_W'(100)) n = 3'd3;
    else if (m >= MAG_W'(10)) n = 3'd2;
    else n = 3'd1;
    return n;
  endfunction

  // scale by ten to sh, truncating for negative sh; reciprocals exact for m up to 32768
  function automatic logic [SUM_W-1:0] scale10(input logic [MAG_W-1:0] m,
                                               input logic signed [SH_W-1:0] sh);
    logic [PROD_W-1:0] p;
    p = '0;
    unique case (sh)
      4'sd3:   p = PROD_W'(m) * PROD_W'(1000);
      4'sd2:   p = PROD_W'(m) * PROD_W'(100);
      4'sd1:   p = PROD_W'(m) * PROD_W'(10);
      4'sd0:   p = PROD_W'(m);
      -4'sd1:  p = (PROD_W'(m) * PROD_W'(52429)) >> 19;
      -4'sd2:  p = (PROD_W'(m) * PROD_W'(5243)) >> 19;
      -4'sd3:  p = (PROD_W'(m) * PROD_W'(33555)) >> 25;
      -4'sd4:  p = (PROD_W'(m) * PROD_W'(53688)) >> 29;
      default: p = '0;
    endcase
    return p[SUM_W-1:0];
  endfunction

  // quotient by ten, exact for x below 2^27
  function automatic logic [SUM_W-1:0] div10(input logic [SUM_W-1:0] x);
    logic [2*SUM_W+2:0] p;
    p = (2*SUM_W+3)'(x) * (2*SUM_W+3)'(107374183);
    return p[SUM_W+29:30];
  endfunction

endpackage
`default_nettype wire

@@ rtl/decimal_float_add_sub_mul.sv @@
// top level: pipelined decimal floating-point add, subtract and multiply
//
// channel   dir  signals                                   word
// command   in   start, busy, cmd, a_mant, a_exp,          one operation
//                b_mant, b_exp
// result    out  done, res_mant, res_exp, wrapped          one result, one cycle
//
// a word enters on every cycle that start is high; busy is always low
// pipeline stages in order: decode, align plan / multiply, scale, sum,
// four trailing-zero strip stages (one divide-by-ten multiply each), format
// results leave in order, one done pulse per accepted word
// rst is synchronous and clears only the valid bits; payload registers are not reset
// the receiver cannot stall, so the pipeline never holds
`timescale 1ns / 1ps
`default_nettype none
module decimal_float_add_sub_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic signed [15:0] a_mant,
  input  wire logic signed [15:0] a_exp,
  input  wire logic signed [15:0] b_mant,
  input  wire logic signed [15:0] b_exp,
  output logic             done,
  output logic signed [15:0] res_mant,
  output logic signed [15:0] res_exp,
  output logic             wrapped
);

  localparam int NSTRIP = dfas_pkg::DIGIT_LIMIT;

  // ---------------- stage 1: decode, magnitudes, digit counts
  logic                           s1_valid;
  logic                           s1_mul, s1_sub, s1_as, s1_bs;
  logic [dfas_pkg::MAG_W-1:0]     s1_am, s1_bm;
  logic signed [dfas_pkg::EXP_W-1:0] s1_ae, s1_be;
  logic [dfas_pkg::K_W-1:0]       s1_nda, s1_ndb;

  logic [dfas_pkg::MAG_W-1:0] a_ext, b_ext, am_c, bm_c;

  assign busy = 1'b0;

  always_comb begin
    a_ext = {a_mant[15], a_mant};
    b_ext = {b_mant[15], b_mant};
    am_c  = a_mant[15] ? (dfas_pkg::MAG_W'(0) - a_ext) : a_ext;
    bm_c  = b_mant[15] ? (dfas_pkg::MAG_W'(0) - b_ext) : b_ext;
  end

  always_ff @(posedge clk) begin
    s1_mul <= cmd[dfas_pkg::CMD_MUL_BIT];
    s1_sub <= (cmd == dfas_pkg::CMD_SUB);
    s1_as  <= a_mant[15];
    s1_bs  <= b_mant[15];
    s1_am  <= am_c;
    s1_bm  <= bm_c;
    s1_ae  <= a_exp;
    s1_be  <= b_exp;
    s1_nda <= dfas_pkg::ndigits(am_c);
    s1_ndb <= dfas_pkg::ndigits(bm_c);
  end

  // ---------------- stage 2: multiply and pass-through results, alignment target
  logic                           s2_valid;
  logic                           s2_bf;     // result already final
  dfas_pkg::byp_t                 s2_byp;
  logic                           s2_an, s2_bn;
  logic [dfas_pkg::MAG_W-1:0]     s2_am, s2_bm;
  logic signed [dfas_pkg::TGT_W-1:0] s2_tgt;
  logic signed [dfas_pkg::SH_W-1:0]  s2_sha, s2_shb;

  logic                           neg_m, bn_e, bf_c;
  logic [dfas_pkg::PROD_W-1:0]    prod, prod_s, lim_m;
  logic signed [dfas_pkg::EXP_W:0] mexp;
  logic [dfas_pkg::MAG_W-1:0]     bneg, aneg;
  dfas_pkg::byp_t                 byp_c;
  logic signed [dfas_pkg::TGT_W-1:0] maga, magb, minx, maxm, tlim, tgt_c;
  logic signed [dfas_pkg::SHD_W-1:0] sha_w, shb_w;
  logic signed [dfas_pkg::SH_W-1:0]  sha_c, shb_c;

  always_comb begin
    neg_m  = s1_as ^ s1_bs;
    prod   = dfas_pkg::PROD_W'(s1_am) * dfas_pkg::PROD_W'(s1_bm);
    prod_s = neg_m ? (dfas_pkg::PROD_W'(0) - prod) : prod;
    lim_m  = dfas_pkg::PROD_W'(dfas_pkg::POS_LIM) + dfas_pkg::PROD_W'(neg_m);
    mexp   = (dfas_pkg::EXP_W+1)'(s1_ae) + (dfas_pkg::EXP_W+1)'(s1_be);
    bn_e   = s1_bs ^ s1_sub;
    bneg   = bn_e ? (dfas_pkg::MAG_W'(0) - s1_bm) : s1_bm;
    aneg   = s1_as ? (dfas_pkg::MAG_W'(0) - s1_am) : s1_am;
    bf_c   = 1'b1;
    byp_c  = '0;
    priority if (s1_mul) begin
      byp_c.mant = prod_s[dfas_pkg::MANT_W-1:0];
      byp_c.expo = mexp[dfas_pkg::EXP_W-1:0];
      byp_c.wrap = (prod > lim_m) | (mexp[dfas_pkg::EXP_W] ^ mexp[dfas_pkg::EXP_W-1]);
    end else if (s1_am == '0) begin
      byp_c.mant = bneg[dfas_pkg::MANT_W-1:0];
      byp_c.expo = s1_be;
      byp_c.wrap = !bn_e && (s1_bm > dfas_pkg::POS_LIM);
    end else if (s1_bm == '0) begin
      byp_c.mant = aneg[dfas_pkg::MANT_W-1:0];
      byp_c.expo = s1_ae;
      byp_c.wrap = !s1_as && (s1_am > dfas_pkg::POS_LIM);
    end else begin
      bf_c = 1'b0;
    end

    // target exponent keeps about DIGIT_LIMIT digits of the larger operand
    maga  = dfas_pkg::TGT_W'(s1_ae) + dfas_pkg::TGT_W'(s1_nda);
    magb  = dfas_pkg::TGT_W'(s1_be) + dfas_pkg::TGT_W'(s1_ndb);
    minx  = (s1_ae < s1_be) ? dfas_pkg::TGT_W'(s1_ae) : dfas_pkg::TGT_W'(s1_be);
    maxm  = (maga > magb) ? maga : magb;
    tlim  = maxm - dfas_pkg::TGT_W'(dfas_pkg::DIGIT_LIMIT);
    tgt_c = (tlim > minx) ? tlim : minx;
    sha_w = dfas_pkg::SHD_W'(s1_ae) - dfas_pkg::SHD_W'(tgt_c);
    shb_w = dfas_pkg::SHD_W'(s1_be) - dfas_pkg::SHD_W'(tgt_c);
    // five or more digits dropped leaves nothing
    sha_c = (sha_w < -19'sd5) ? -4'sd5 : dfas_pkg::SH_W'(sha_w);
    shb_c = (shb_w < -19'sd5) ? -4'sd5 : dfas_pkg::SH_W'(shb_w);
  end

  always_ff @(posedge clk) begin
    s2_bf  <= bf_c;
    s2_byp <= byp_c;
    s2_an  <= s1_as;
    s2_bn  <= bn_e;
    s2_am  <= s1_am;
    s2_bm  <= s1_bm;
    s2_tgt <= tgt_c;
    s2_sha <= sha_c;
    s2_shb <= shb_c;
  end

  // ---------------- stage 3: align both mantissas to the target
  logic                           s3_valid, s3_bf, s3_an, s3_bn;
  dfas_pkg::byp_t                 s3_byp;
  logic [dfas_pkg::SUM_W-1:0]     s3_xa, s3_xb;
  logic signed [dfas_pkg::TGT_W-1:0] s3_tgt;

  always_ff @(posedge clk) begin
    s3_bf  <= s2_bf;
    s3_byp <= s2_byp;
    s3_an  <= s2_an;
    s3_bn  <= s2_bn;
    s3_xa  <= dfas_pkg::scale10(s2_am, s2_sha);
    s3_xb  <= dfas_pkg::scale10(s2_bm, s2_shb);
    s3_tgt <= s2_tgt;
  end

  // ---------------- stage 4: signed magnitude sum, feeds the strip chain at index 0
  logic                           st_valid [0:NSTRIP];
  logic                           st_bf    [0:NSTRIP];
  dfas_pkg::byp_t                 st_byp   [0:NSTRIP];
  logic                           st_neg   [0:NSTRIP];
  logic [dfas_pkg::SUM_W-1:0]     st_sum   [0:NSTRIP];
  logic [dfas_pkg::K_W-1:0]       st_k     [0:NSTRIP];
  logic signed [dfas_pkg::TGT_W-1:0] st_tgt [0:NSTRIP];

  logic [dfas_pkg::SUM_W-1:0] sum_c;
  logic                       neg_c;

  always_comb begin
    priority if (s3_an == s3_bn) begin
      sum_c = s3_xa + s3_xb;
      neg_c = s3_an;
    end else if (s3_xa >= s3_xb) begin
      sum_c = s3_xa - s3_xb;
      neg_c = s3_an;
    end else begin
      sum_c = s3_xb - s3_xa;
      neg_c = s3_bn;
    end
    if (sum_c == '0) begin
      neg_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    st_bf[0]  <= s3_bf;
    st_byp[0] <= s3_byp;
    st_neg[0] <= neg_c;
    st_sum[0] <= sum_c;
    st_k[0]   <= '0;
    st_tgt[0] <= s3_tgt;
  end

  // ---------------- strip stages: one trailing zero per stage
  // once a digit is nonzero it stays so, no stop flag is needed
  for (genvar i = 0; i < NSTRIP; i++) begin : g_strip
    logic [dfas_pkg::SUM_W-1:0] q;
    logic                       rz;

    always_comb begin
      q  = dfas_pkg::div10(st_sum[i]);
      rz = (st_sum[i] == ((q << 3) + (q << 1)));
    end

    always_ff @(posedge clk) begin
      st_bf[i+1]  <= st_bf[i];
      st_byp[i+1] <= st_byp[i];
      st_neg[i+1] <= st_neg[i];
      st_sum[i+1] <= rz ? q : st_sum[i];
      st_k[i+1]   <= rz ? (st_k[i] + 3'd1) : st_k[i];
      st_tgt[i+1] <= st_tgt[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[i+1] <= 1'b0;
      end else begin
        st_valid[i+1] <= st_valid[i];
      end
    end
  end

  // ---------------- output stage: final exponent, sign and range checks
  logic signed [dfas_pkg::SHD_W-1:0] e_c;
  logic [dfas_pkg::SUM_W-1:0]        msig, mlim;
  dfas_pkg::byp_t                    fin_c;

  always_comb begin
    e_c  = dfas_pkg::SHD_W'(st_tgt[NSTRIP]) + dfas_pkg::SHD_W'(st_k[NSTRIP]);
    msig = st_neg[NSTRIP] ? (dfas_pkg::SUM_W'(0) - st_sum[NSTRIP]) : st_sum[NSTRIP];
    mlim = dfas_pkg::SUM_W'(dfas_pkg::POS_LIM) + dfas_pkg::SUM_W'(st_neg[NSTRIP]);
    if (st_bf[NSTRIP]) begin
      fin_c = st_byp[NSTRIP];
    end else begin
      fin_c.mant = msig[dfas_pkg::MANT_W-1:0];
      fin_c.expo = e_c[dfas_pkg::EXP_W-1:0];
      // exponent fits only if all bits above the sign agree
      fin_c.wrap = (st_sum[NSTRIP] > mlim) ||
                   !((e_c[dfas_pkg::SHD_W-1:dfas_pkg::EXP_W-1] == '0) ||
                     (e_c[dfas_pkg::SHD_W-1:dfas_pkg::EXP_W-1] == '1));
    end
  end

  always_ff @(posedge clk) begin
    res_mant <= fin_c.mant;
    res_exp  <= fin_c.expo;
    wrapped  <= fin_c.wrap;
  end

  // ---------------- valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      st_valid[0] <= 1'b0;
      done        <= 1'b0;
    end else begin
      s1_valid    <= start & ~busy;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      st_valid[0] <= s3_valid;
      done        <= st_valid[NSTRIP];
    end
  end

endmodule
`default_nettype wire

@@ test/tb_decimal_float_add_sub_mul.sv @@
// testbench for the decimal float add, subtract and multiply unit
`timescale 1ns / 1ps
`default_nettype none
module tb_decimal_float_add_sub_mul;

  // mantissa, exponent and wrap flag of one result word
  typedef struct {
    logic signed [15:0] mant;
    logic signed [15:0] expo;
    logic               wrap;
  } dec_result_t;

  // one row of the directed table; known marks a hand-typed answer
  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] am;
    logic signed [15:0] ae;
    logic signed [15:0] bm;
    logic signed [15:0] be;
    bit                 known;
    dec_result_t        ans;
  } dec_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] cmd;
  logic signed [15:0] a_mant, a_exp, b_mant, b_exp;
  logic done;
  logic signed [15:0] res_mant, res_exp;
  logic wrapped;

  dec_result_t pending_results[$];
  dec_result_t row_answer;
  bit          row_known;
  int          mismatch_count = 0;

  decimal_float_add_sub_mul dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .a_mant(a_mant), .a_exp(a_exp), .b_mant(b_mant), .b_exp(b_exp),
    .done(done), .res_mant(res_mant), .res_exp(res_exp), .wrapped(wrapped)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic longint digit_count(input longint m);
    longint n;
    n = 1;
    while (m >= 10) begin
      m = m / 10;
      n++;
    end
    return n;
  endfunction

  // shift a magnitude by sh decimal places, truncating digits that fall off
  function automatic longint shift_decimal(input longint m, input longint sh);
    longint i;
    if (sh >= 0) begin
      for (i = 0; i < sh && i < 20; i++) m = m * 10;
    end else if (sh < -20) begin
      m = 0;
    end else begin
      for (i = 0; i < -sh; i++) m = m / 10;
    end
    return m;
  endfunction

  function automatic bit exp_out_of_range(input longint e);
    return e > 32767 || e < -32768;
  endfunction

  function automatic bit mag_too_big(input bit neg, input longint mag);
    return neg ? (mag > 32768) : (mag > 32767);
  endfunction

  function automatic dec_result_t pack_result(input bit neg, input longint mag,
                                              input longint e, input bit w);
    dec_result_t r;
    longint v;
    v = neg ? -mag : mag;
    r.mant = v[15:0];
    r.expo = e[15:0];
    r.wrap = w;
    return r;
  endfunction

  // expected result of one operation
  function automatic dec_result_t decimal_result(input logic [1:0] op,
      input logic signed [15:0] am_in, input logic signed [15:0] ae_in,
      input logic signed [15:0] bm_in, input logic signed [15:0] be_in);
    longint av, ae, bv, be, am, bm, lim, prod_e;
    longint mag_a, mag_b, minexp, maxmag, target, xa, xb, sum, k, e;
    bit an, bn, neg, movf;
    av = am_in; ae = ae_in; bv = bm_in; be = be_in;
    an = av < 0; bn = bv < 0;
    am = an ? -av : av;
    bm = bn ? -bv : bv;
    if (op[dfas_pkg::CMD_MUL_BIT]) begin
      neg = an != bn;
      lim = neg ? 32768 : 32767;
      movf = am != 0 && bm > lim / am;
      prod_e = ae + be;
      return pack_result(neg, am * bm, prod_e, movf || exp_out_of_range(prod_e));
    end
    if (op == dfas_pkg::CMD_SUB) bn = !bn;
    // a zero operand passes the other one through
    if (am == 0) return pack_result(bn, bm, be, mag_too_big(bn, bm));
    if (bm == 0) return pack_result(an, am, ae, mag_too_big(an, am));
    mag_a = ae + digit_count(am);
    mag_b = be + digit_count(bm);
    minexp = ae < be ? ae : be;
    maxmag = mag_a > mag_b ? mag_a : mag_b;
    target = (maxmag - dfas_pkg::DIGIT_LIMIT > minexp) ? maxmag - dfas_pkg::DIGIT_LIMIT
                                                        : minexp;
    xa = shift_decimal(am, ae - target);
    xb = shift_decimal(bm, be - target);
    if (an == bn) begin
      sum = xa + xb; neg = an;
    end else if (xa >= xb) begin
      sum = xa - xb; neg = an;
    end else begin
      sum = xb - xa; neg = bn;
    end
    if (sum == 0) neg = 1'b0;
    k = 0;
    while (k < dfas_pkg::DIGIT_LIMIT && sum % 10 == 0) begin
      sum = sum / 10;
      k++;
    end
    e = target + k;
    return pack_result(neg, sum, e, mag_too_big(neg, sum) || exp_out_of_range(e));
  endfunction

  // a word is taken at an edge with start high and busy low
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      if (row_known) pending_results.push_back(row_answer);
      else pending_results.push_back(decimal_result(cmd, a_mant, a_exp, b_mant, b_exp));
    end
  end

  // every done pulse is compared with the oldest expected word
  always @(posedge clk) begin
    dec_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, mant", res_mant, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_mant !== want.mant) report_mismatch("res_mant", res_mant, want.mant);
        if (res_exp !== want.expo) report_mismatch("res_exp", res_exp, want.expo);
        if (wrapped !== want.wrap) report_mismatch("wrapped", wrapped, want.wrap);
      end
    end
  end

  // drive one word, hold it until accepted, then idle gap cycles
  task automatic send_word(input logic [1:0] op, input logic signed [15:0] am,
      input logic signed [15:0] ae, input logic signed [15:0] bm,
      input logic signed [15:0] be, input bit known, input dec_result_t ans, input int gap);
    start <= 1'b1;
    cmd <= op; a_mant <= am; a_exp <= ae; b_mant <= bm; b_exp <= be;
    row_known <= known; row_answer <= ans;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] pick_mant();
    case ($urandom_range(0, 7))
      0: return 16'sh0000;
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2, 3: return 16'($signed($urandom_range(0, 199)) - 100);
      4: return 16'($signed($urandom_range(0, 3276)) * 10);
      5: return 16'($signed($urandom_range(0, 326)) * 100 - 16300);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic signed [15:0] pick_exp();
    case ($urandom_range(0, 7))
      0: return 16'($urandom());
      1: return $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 4))
                                      : 16'sh8000 + 16'($urandom_range(0, 4));
      default: return 16'($signed($urandom_range(0, 24)) - 12);
    endcase
  endfunction

  dec_row_t directed [20] = '{
    // zero plus zero passes b through
    '{dfas_pkg::CMD_ADD, 16'sd0, 16'sd5, 16'sd0, 16'sd7, 1'b1, '{16'sd0, 16'sd7, 1'b0}},
    // subtracting the most negative mantissa from zero wraps
    '{dfas_pkg::CMD_SUB, 16'sd0, 16'sd0, -16'sd32768, 16'sd3, 1'b1,
      '{-16'sd32768, 16'sd3, 1'b1}},
    // b zero passes a through
    '{dfas_pkg::CMD_ADD, 16'sd32767, -16'sd32768, 16'sd0, 16'sd9, 1'b1,
      '{16'sd32767, -16'sd32768, 1'b0}},
    // product exponent overflow
    '{dfas_pkg::CMD_MUL, 16'sd32767, 16'sd32767, 16'sd1, 16'sd1, 1'b1,
      '{16'sd32767, -16'sd32768, 1'b1}},
    // negated minimum in multiply
    '{dfas_pkg::CMD_MUL, -16'sd32768, 16'sd0, -16'sd1, 16'sd0, 1'b1,
      '{-16'sd32768, 16'sd0, 1'b1}},
    // opcode three multiplies
    '{dfas_pkg::CMD_MUL | dfas_pkg::CMD_SUB, 16'sd12, 16'sd2, 16'sd11, -16'sd3, 1'b1,
      '{16'sd132, -16'sd1, 1'b0}},
    '{dfas_pkg::CMD_MUL, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0,
      '{0, 0, 0}},
    '{dfas_pkg::CMD_MUL, 16'sd0, 16'sd100, -16'sd5, 16'sd3, 1'b0, '{0, 0, 0}},
    '{dfas_pkg::CMD_MUL, 16'sd181, 16'sd0, 16'sd181, 16'sd0, 1'b0, '{0, 0, 0}},
    // zero sum gets stripped
    '{dfas_pkg::CMD_ADD, 16'sd25, 16'sd1, -16'sd25, 16'sd1, 1'b0, '{0, 0, 0}},
    '{dfas_pkg::CMD_SUB, 16'sd77, -16'sd2, 16'sd77, -16'sd2, 1'b0, '{0, 0, 0}},
    // alignment truncates dropped digits
    '{dfas_pkg::CMD_ADD, 16'sd32767, 16'sd0, 16'sd12345, -16'sd3, 1'b0, '{0, 0, 0}},
    '{dfas_pkg::CMD_ADD, -16'sd32768, 16'sd10, 16'sd1, -16'sd10, 1'b0, '{0, 0, 0}},
    '{dfas_pkg::CMD_SUB, 16'sd32767, 16'sd0, -16'sd32767, 16'sd0, 1'b0, '{0, 0, 0}},
    '{dfas_pkg::CMD_ADD, -16'sd32768, 16'sd0, -16'sd32768, 16'sd0, 1'b0, '{0, 0, 0}},
    '{dfas_pkg::CMD_ADD, 16'sd9999, 16'sd32767, 16'sd1, 16'sd32767, 1'b0, '{0, 0, 0}},
    '{dfas_pkg::CMD_SUB, 16'sd1, -16'sd32768, 16'sd3, -16'sd32768, 1'b0, '{0, 0, 0}},
    '{dfas_pkg::CMD_ADD, 16'sd5000, 16'sd0, 16'sd5000, 16'sd0, 1'b0, '{0, 0, 0}},
    '{dfas_pkg::CMD_ADD, 16'sd1, 16'sd32767, -16'sd1, -16'sd32768, 1'b0, '{0, 0, 0}},
    '{dfas_pkg::CMD_SUB, -16'sd1, 16'sd4, 16'sd9999, 16'sd0, 1'b0, '{0, 0, 0}}
  };

  initial begin
    dec_result_t none;
    int gap_mode;
    none = '{16'sd0, 16'sd0, 1'b0};
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0; a_mant <= '0; a_exp <= '0; b_mant <= '0; b_exp <= '0;
    row_known <= 1'b0; row_answer <= none;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_word(directed[i].op, directed[i].am, directed[i].ae, directed[i].bm,
                directed[i].be, directed[i].known, directed[i].ans, $urandom_range(0, 3));

    // random part; every 50 words decide between back-to-back and random gaps
    gap_mode = 0;
    for (int n = 0; n < 750; n++) begin
      if (n % 50 == 0) gap_mode = $urandom_range(0, 2);
      send_word(2'($urandom_range(0, 3)), pick_mant(), pick_exp(), pick_mant(), pick_exp(),
                1'b0, none, gap_mode == 0 ? 0 : $urandom_range(0, 14));
    end
    start <= 1'b0;

    // drain, then allow for the pipeline depth
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
